// ----- design/sksi_pkg.sv -----
package sksi_pkg;

  // Default geometry of the key store
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 32;

  // Fixed field widths on the ports
  localparam int IN_KEY_W = 32;
  localparam int STATUS_W = 3;

  // Request codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the incoming key
    logic ins;       // open a gap and store the key
    logic rem;       // close the gap over the matching key
    logic res_we;    // latch the result position
    logic pos_zero;  // report position zero
  } cmd_t;

  // Search status from the datapath
  typedef struct packed {
    logic hit;   // key is held
    logic full;  // store holds CAPACITY keys
  } stat_t;

endpackage

// ----- design/sksi_datapath.sv -----
module sksi_datapath
  import sksi_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IN_KEY_W-1:0] in_key,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic [CNT_W-1:0]    position,
  output logic [CNT_W-1:0]    entry_count
);

  logic [63:0]          key_ext;
  logic [KEY_BITS-1:0]  key_r;
  logic [KEY_BITS-1:0]  slot_r [CAPACITY];
  logic [CAPACITY-1:0]  vld;
  logic [CAPACITY-1:0]  lt;
  logic [CAPACITY-1:0]  eq;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CNT_W-1:0]     pos_r;

  // Keep only the low KEY_BITS bits of the key word
  assign key_ext = {{(64 - IN_KEY_W){1'b0}}, in_key};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_ext[KEY_BITS-1:0];
    end
  end

  // Compare every held slot against the key at once
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vld[i] = CNT_W'(i) < count_r;
      lt[i]  = vld[i] && (slot_r[i] < key_r);
      eq[i]  = vld[i] && (slot_r[i] == key_r);
    end
  end

  // Flags below the key form a thermometer: its first zero is the lower bound
  always_comb begin
    idx = CNT_W'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt[i]) begin
        idx = CNT_W'(i);
      end
    end
  end

  assign stat.hit  = |eq;
  assign stat.full = (count_r == CNT_W'(CAPACITY));

  // Shift slots up on insert, down on remove
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic [KEY_BITS-1:0] slot_nxt;
    logic                at_gap;
    logic [KEY_BITS-1:0] below;
    logic [KEY_BITS-1:0] above;

    if (g == 0) begin : g_first
      assign at_gap = 1'b1;
      assign below  = key_r;
    end else begin : g_rest
      assign at_gap = lt[g-1];
      assign below  = slot_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign above = slot_r[g];
    end else begin : g_inner
      assign above = slot_r[g+1];
    end

    always_comb begin
      slot_nxt = slot_r[g];
      if (cmd.ins && !lt[g]) begin
        slot_nxt = at_gap ? key_r : below;
      end else if (cmd.rem && !lt[g]) begin
        slot_nxt = above;
      end
    end

    always_ff @(posedge clk) begin
      slot_r[g] <= slot_nxt;
    end
  end

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the reported position
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      pos_r <= cmd.pos_zero ? '0 : idx;
    end
  end

  assign position    = pos_r;
  assign entry_count = count_r;

endmodule

// ----- design/sksi_ctrl.sv -----
module sksi_ctrl
  import sksi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_op,
  input  stat_t               stat,
  output cmd_t                cmd,
  output logic                busy,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic                op_r;
  logic                valid_r;
  logic                valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;

  // Decide the action from the search status
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = EXEC;
        end
      end
      EXEC: begin
        cmd.res_we = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = IDLE;
        if (op_r == OP_INSERT) begin
          if (stat.hit) begin
            status_nxt = ST_PRESENT;
          end else if (stat.full) begin
            status_nxt   = ST_FULL;
            cmd.pos_zero = 1'b1;
          end else begin
            status_nxt = ST_INSERTED;
            cmd.ins    = 1'b1;
          end
        end else begin
          if (stat.hit) begin
            status_nxt = ST_REMOVED;
            cmd.rem    = 1'b1;
          end else begin
            status_nxt   = ST_NOT_FOUND;
            cmd.pos_zero = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= IDLE;
      valid_r  <= 1'b0;
      status_r <= ST_INSERTED;
      op_r     <= OP_INSERT;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
      if (cmd.load) begin
        op_r <= in_op;
      end
    end
  end

  assign busy       = (state_r != IDLE);
  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

// ----- design/sorted_key_set_insert_remove_top.sv -----
// Sorted key set: holds up to CAPACITY unique keys in ascending order.
// Input channel: a request word (in_op, in_key) is taken at a rising edge
// where start is high and busy is low. in_op selects insert or remove.
// Result channel: out_valid marks a word for exactly one cycle carrying
// out_status, out_position (sorted index found or placed, else zero) and
// out_entry_count (keys held after the request). The receiver cannot stall.
// Timing: the edge that takes a request moves the block into its execute
// cycle, in which every slot compares against the key in parallel and the
// row of slots shifts up or down in that same step. The result word shows
// in the next cycle, while busy is already low again, so a new request can
// be taken in the result cycle. No new request is taken during the execute
// cycle, so requests never overlap.
// Reset (rst_n low, synchronous) empties the set and drops any result;
// slot contents are left as they are and are never read past the count.
module sorted_key_set_insert_remove_top
  import sksi_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_op,
  input  logic [IN_KEY_W-1:0] in_key,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_position,
  output logic [CNT_W-1:0]    out_entry_count
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request
  sksi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_op),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  // Compare and shift the key slots
  sksi_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key      (in_key),
    .cmd         (cmd),
    .stat        (stat),
    .position    (out_position),
    .entry_count (out_entry_count)
  );

endmodule

// ----- design/sksi_checker.sv -----
module sksi_checker
  import sksi_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [CNT_W-1:0]    out_position,
  input logic [CNT_W-1:0]    out_entry_count
);

  // Every accepted word yields its result once its execute cycle is over
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word gave no result");

  // A result is never invented without a preceding execute cycle
  a_result_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in flight");

  // The block takes a new word while a result is shown
  a_ready_on_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // An inserted key lands inside the held range
  a_insert_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INSERTED) |-> out_position < out_entry_count)
    else $error("insert position outside held range");

  // The count never exceeds the capacity
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sorted_key_set_insert_remove_top sksi_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_sksi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count)
);

// ----- test/sorted_key_set_insert_remove_top_tb.sv -----
module sorted_key_set_insert_remove_top_tb;
  import sksi_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int CNT_W      = $clog2(DEF_CAPACITY + 1);
  localparam int POOL_SIZE  = 96;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    position;
    logic [CNT_W-1:0]    entry_count;
  } result_t;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic                in_op   = OP_INSERT;
  logic [IN_KEY_W-1:0] in_key  = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_position;
  logic [CNT_W-1:0]    out_entry_count;

  // Shadow copy of the sorted set
  logic [IN_KEY_W-1:0] held_keys [CAP];
  int                  held_count;

  result_t             pending_results [$];
  result_t             oldest_result;
  logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];
  int                  errors = 0;
  int                  words_sent;
  int                  status_seen [5] = '{default: 0};
  int                  stall_cycles = 0;

  sorted_key_set_insert_remove_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow set and return the result word it causes
  function automatic result_t apply_request(logic op, logic [IN_KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    logic    hit;
    result_t r;
    lo = 0;
    hi = held_count;
    // lower bound: first entry not below the key
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < held_count) && (held_keys[lo] == key);
    r.position = '0;
    if (op == OP_INSERT) begin
      if (hit) begin
        r.status   = ST_PRESENT;
        r.position = CNT_W'(lo);
      end else if (held_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        for (int i = held_count; i > lo; i--) held_keys[i] = held_keys[i-1];
        held_keys[lo] = key;
        held_count++;
        r.status   = ST_INSERTED;
        r.position = CNT_W'(lo);
      end
    end else begin
      if (hit) begin
        for (int i = lo; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
        r.status   = ST_REMOVED;
        r.position = CNT_W'(lo);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.entry_count = CNT_W'(held_count);
    return r;
  endfunction

  // Send one request word, idling first at the given percentage per cycle
  task automatic send_word(logic op, logic [IN_KEY_W-1:0] key, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start  <= 1'b1;
    in_op  <= op;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_request(op, key));
    words_sent++;
  endtask

  // Hold the sender until every expected result word has come back
  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Mostly keys from a small pool so that hits are common
  function automatic logic [IN_KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (sel < 85)
      return key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  task automatic run_random_phase(int count, int idle_pct, int insert_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_word(op, pick_key(), idle_pct);
      if (i == count / 2) wait_all_results();
    end
    wait_all_results();
  endtask

  task automatic test_empty_set();
    send_word(OP_REMOVE, 32'h0000_0000, 0);
    send_word(OP_REMOVE, 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_key_extremes();
    send_word(OP_INSERT, 32'hFFFF_FFFF, 0);
    send_word(OP_INSERT, 32'h0000_0000, 0);
    send_word(OP_INSERT, 32'h8000_0000, 0);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 0);
    send_word(OP_INSERT, 32'h0000_0001, 0);
    send_word(OP_INSERT, 32'hFFFF_FFFE, 0);
  endtask

  task automatic test_duplicate_insert();
    send_word(OP_INSERT, 32'h0000_0000, 0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 0);
    send_word(OP_INSERT, 32'h8000_0000, 0);
  endtask

  task automatic test_remove_positions();
    send_word(OP_REMOVE, 32'h0000_0000, 0);
    send_word(OP_REMOVE, 32'hFFFF_FFFF, 0);
    send_word(OP_REMOVE, 32'h8000_0000, 0);
    send_word(OP_REMOVE, 32'h8000_0000, 0);
    send_word(OP_REMOVE, 32'h1234_5678, 0);
  endtask

  task automatic test_bit_patterns();
    send_word(OP_INSERT, 32'hAAAA_AAAA, 0);
    send_word(OP_INSERT, 32'h5555_5555, 0);
    send_word(OP_REMOVE, 32'hAAAA_AAAA, 0);
    send_word(OP_REMOVE, 32'h5555_5555, 0);
  endtask

  // Insert-heavy with no idling: reaches a full set and refused inserts
  task automatic test_fill_to_full();
    run_random_phase(450, 0, 80);
  endtask

  task automatic test_sparse_sender();
    run_random_phase(450, 79, 50);
  endtask

  // Remove-heavy: thins the set out and mixes hits with misses
  task automatic test_drain_to_empty();
    run_random_phase(450, 0, 20);
  endtask

  task automatic test_light_idle_mix();
    run_random_phase(450, 27, 60);
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: status %0d position %0d count %0d",
               out_status, out_position, out_entry_count);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status) begin
          $error("out_status: expected %0d, got %0d", oldest_result.status, out_status);
          errors++;
        end
        if (out_position !== oldest_result.position) begin
          $error("out_position: expected %0d, got %0d", oldest_result.position, out_position);
          errors++;
        end
        if (out_entry_count !== oldest_result.entry_count) begin
          $error("out_entry_count: expected %0d, got %0d",
                 oldest_result.entry_count, out_entry_count);
          errors++;
        end
        if (oldest_result.status <= ST_FULL) status_seen[oldest_result.status]++;
      end
    end
  end

  // Drop the run when no word moves on either side for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    words_sent   = 0;
    held_count   = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_set();
    test_key_extremes();
    test_duplicate_insert();
    test_remove_positions();
    test_bit_patterns();
    wait_all_results();
    test_fill_to_full();
    test_sparse_sender();
    test_drain_to_empty();
    test_light_idle_mix();

    // let the last word settle
    wait_all_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests over directed and four random phases.", words_sent);
    $display("Results: %0d inserted, %0d present, %0d removed, %0d not found, %0d full.",
             status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_REMOVED],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected result words never came", pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
